>>> rtl/greedy_rectangle_merge_core_assert.svh
// Assertion macros used by the checker file of the rectangle merge core.
`ifndef GREEDY_RECTANGLE_MERGE_CORE_ASSERT_SVH
`define GREEDY_RECTANGLE_MERGE_CORE_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define GRM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rectangle merge check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define GRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rectangle merge check failed");

`endif

>>> rtl/grm_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle merge package
// Sizes, command codes, sequencer states and address helper of the core.
// ----------------------------------------------------------------------------
package grm_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int TILE_BITS  = 8;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int DIM_W  = 7;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_WRITE   = 2'd0;
	localparam cmd_t CMD_FETCH   = 2'd1;
	localparam cmd_t CMD_RESTART = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CK,
		ST_DECIDE,
		ST_GX_RD,
		ST_GX_CK,
		ST_GY_RD,
		ST_GY_CK,
		ST_MARK,
		ST_EMIT
	} state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row);
		return {row, col};
	endfunction

	// A size of zero acts as one, a size above the store acts as the store size.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] res;
		res = v;
		if (v == '0) res = DIM_W'(1);
		else if (v > maxv) res = maxv;
		return res;
	endfunction

endpackage

>>> rtl/greedy_rectangle_merge_core.sv
// Sequence: a write or an unused command needs only the transfer; a restart adds the mark
// clearing pass over all 4096 cells, one mark cell per cycle. A fetch runs the transfer, a
// read and a check per scanned cell, a step per row change of the scan, a read and a check
// per cell checked while growing, a step per growth decision and covered cell, then the emit.
// After reset the same clearing pass runs before the first item is taken.
// Throughput: one item at a time; a finished result waits in the output register.
// ----------------------------------------------------------------------------
// Greedy rectangle merge core
// Stores a tile grid and returns, per fetch, the next maximal rectangle.
// ----------------------------------------------------------------------------
module greedy_rectangle_merge_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic [grm_pkg::COL_W-1:0]         cell_col,
	input  logic [grm_pkg::ROW_W-1:0]         cell_row,
	input  logic [grm_pkg::TILE_BITS-1:0]     cell_tile,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [grm_pkg::COL_W-1:0]         rect_col_first,
	output logic [grm_pkg::ROW_W-1:0]         rect_row_first,
	output logic [grm_pkg::COL_W-1:0]         rect_col_last,
	output logic [grm_pkg::ROW_W-1:0]         rect_row_last,
	output logic [grm_pkg::TILE_BITS-1:0]     rect_tile,
	output logic                              scan_done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [grm_pkg::DIM_W-1:0]         cfg_data
);

	localparam int COL_W  = grm_pkg::COL_W;
	localparam int ROW_W  = grm_pkg::ROW_W;
	localparam int ADDR_W = grm_pkg::ADDR_W;
	localparam int DIM_W  = grm_pkg::DIM_W;
	localparam int TW     = grm_pkg::TILE_BITS;

	grm_pkg::state_t state_q, state_d;

	logic [TW-1:0]     tile_mem [grm_pkg::CELLS];
	logic              mark_mem [grm_pkg::CELLS];
	logic [TW-1:0]     tile_rd_q;
	logic              mark_rd_q;

	logic [DIM_W-1:0]  width_q, height_q, w, h;
	logic [DIM_W-1:0]  scan_col_q, scan_row_q;
	logic              finished_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [COL_W-1:0]  xe_q, mi_q;
	logic [ROW_W-1:0]  ye_q, mj_q;
	logic [COL_W-1:0]  idx_q;
	logic [TW-1:0]     t_q;
	logic              sx_q, sy_q, done_q;

	logic [ADDR_W-1:0] rd_addr, mark_waddr;
	logic              mark_we, mark_wdata, tile_we, in_acc, grow_ok, emit_go;

	assign w         = grm_pkg::clamp_dim(width_q, DIM_W'(grm_pkg::MAX_WIDTH));
	assign h         = grm_pkg::clamp_dim(height_q, DIM_W'(grm_pkg::MAX_HEIGHT));
	assign in_ready  = (state_q == grm_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign tile_we   = in_acc && (cmd == grm_pkg::CMD_WRITE);
	assign grow_ok   = (tile_rd_q == t_q) && !mark_rd_q;
	assign emit_go   = !out_valid || out_ready;

	always_comb begin
		state_d    = state_q;
		rd_addr    = grm_pkg::cell_addr(scan_col_q[COL_W-1:0], scan_row_q[ROW_W-1:0]);
		mark_we    = 1'b0;
		mark_wdata = 1'b0;
		mark_waddr = clr_cnt_q[ADDR_W-1:0];
		unique case (state_q)
			grm_pkg::ST_CLEAR: begin
				mark_we = 1'b1;
				if (clr_cnt_q[ADDR_W-1:0] == '1) state_d = grm_pkg::ST_IDLE;
			end
			grm_pkg::ST_IDLE: begin
				if (in_acc && cmd == grm_pkg::CMD_FETCH) state_d = grm_pkg::ST_SCAN_RD;
				else if (in_acc && cmd == grm_pkg::CMD_RESTART) state_d = grm_pkg::ST_CLEAR;
			end
			grm_pkg::ST_SCAN_RD: begin
				if (finished_q || scan_row_q >= h) state_d = grm_pkg::ST_EMIT;
				else if (scan_col_q < w) state_d = grm_pkg::ST_SCAN_CK;
			end
			grm_pkg::ST_SCAN_CK: begin
				if (!mark_rd_q && tile_rd_q != '0) state_d = grm_pkg::ST_DECIDE;
				else state_d = grm_pkg::ST_SCAN_RD;
			end
			grm_pkg::ST_DECIDE: begin
				if (!sx_q) state_d = grm_pkg::ST_GX_RD;
				else if (!sy_q) state_d = grm_pkg::ST_GY_RD;
				else state_d = grm_pkg::ST_MARK;
			end
			grm_pkg::ST_GX_RD: begin
				rd_addr = grm_pkg::cell_addr(xe_q + COL_W'(1), idx_q);
				state_d = grm_pkg::ST_GX_CK;
			end
			grm_pkg::ST_GX_CK: begin
				if (!grow_ok || idx_q == ye_q)
					state_d = sy_q ? grm_pkg::ST_DECIDE : grm_pkg::ST_GY_RD;
				else state_d = grm_pkg::ST_GX_RD;
			end
			grm_pkg::ST_GY_RD: begin
				rd_addr = grm_pkg::cell_addr(idx_q, ye_q + ROW_W'(1));
				state_d = grm_pkg::ST_GY_CK;
			end
			grm_pkg::ST_GY_CK: begin
				if (!grow_ok || idx_q == xe_q) state_d = grm_pkg::ST_DECIDE;
				else state_d = grm_pkg::ST_GY_RD;
			end
			grm_pkg::ST_MARK: begin
				mark_we    = 1'b1;
				mark_wdata = 1'b1;
				mark_waddr = grm_pkg::cell_addr(mi_q, mj_q);
				if (mi_q == xe_q && mj_q == ye_q) state_d = grm_pkg::ST_EMIT;
			end
			grm_pkg::ST_EMIT: begin
				if (emit_go) state_d = grm_pkg::ST_IDLE;
			end
			default: state_d = grm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= grm_pkg::ST_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (tile_we) tile_mem[grm_pkg::cell_addr(cell_col, cell_row)] <= cell_tile;
		tile_rd_q <= tile_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
		mark_rd_q <= mark_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(grm_pkg::MAX_WIDTH);
			height_q <= DIM_W'(grm_pkg::MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == grm_pkg::REG_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data;
		end
	end

	// Scan position, finish flag and clearing counter are control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_col_q <= '0;
			scan_row_q <= '0;
			finished_q <= 1'b0;
			clr_cnt_q  <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (state_q == grm_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (in_acc && cmd == grm_pkg::CMD_RESTART) begin
				scan_col_q <= '0;
				scan_row_q <= '0;
				finished_q <= 1'b0;
				clr_cnt_q  <= '0;
			end
			if (state_q == grm_pkg::ST_SCAN_RD) begin
				if (finished_q || scan_row_q >= h) finished_q <= 1'b1;
				else if (scan_col_q >= w) begin
					scan_col_q <= '0;
					scan_row_q <= scan_row_q + 1'b1;
				end
			end
			if (state_q == grm_pkg::ST_SCAN_CK && !(!mark_rd_q && tile_rd_q != '0))
				scan_col_q <= scan_col_q + 1'b1;
			if (state_q == grm_pkg::ST_EMIT && emit_go) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			grm_pkg::ST_SCAN_RD: begin
				done_q <= finished_q || scan_row_q >= h;
			end
			grm_pkg::ST_SCAN_CK: begin
				t_q  <= tile_rd_q;
				xe_q <= scan_col_q[COL_W-1:0];
				ye_q <= scan_row_q[ROW_W-1:0];
				sx_q <= (scan_col_q + 1'b1) == w;
				sy_q <= (scan_row_q + 1'b1) == h;
			end
			grm_pkg::ST_DECIDE: begin
				mi_q <= scan_col_q[COL_W-1:0];
				mj_q <= scan_row_q[ROW_W-1:0];
				idx_q <= !sx_q ? COL_W'(scan_row_q[ROW_W-1:0]) : scan_col_q[COL_W-1:0];
			end
			grm_pkg::ST_GX_CK: begin
				if (!grow_ok) sx_q <= 1'b1;
				else if (idx_q == ye_q) begin
					xe_q <= xe_q + 1'b1;
					sx_q <= ({1'b0, xe_q} + DIM_W'(2)) == w;
				end
				if (!grow_ok || idx_q == ye_q) idx_q <= scan_col_q[COL_W-1:0];
				else idx_q <= idx_q + 1'b1;
			end
			grm_pkg::ST_GY_CK: begin
				idx_q <= idx_q + 1'b1;
				if (!grow_ok) sy_q <= 1'b1;
				else if (idx_q == xe_q) begin
					ye_q <= ye_q + 1'b1;
					sy_q <= ({1'b0, ye_q} + DIM_W'(2)) == h;
				end
			end
			grm_pkg::ST_MARK: begin
				if (mi_q == xe_q) begin
					mi_q <= scan_col_q[COL_W-1:0];
					mj_q <= mj_q + 1'b1;
				end else mi_q <= mi_q + 1'b1;
			end
			grm_pkg::ST_EMIT: begin
				if (emit_go) begin
					scan_done      <= done_q;
					rect_col_first <= done_q ? '0 : scan_col_q[COL_W-1:0];
					rect_row_first <= done_q ? '0 : scan_row_q[ROW_W-1:0];
					rect_col_last  <= done_q ? '0 : xe_q;
					rect_row_last  <= done_q ? '0 : ye_q;
					rect_tile      <= done_q ? '0 : t_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/grm_checker.sv
// ----------------------------------------------------------------------------
// Rectangle merge port checker
// Watches the result channel of the core for well-formed rectangles.
// ----------------------------------------------------------------------------
`include "greedy_rectangle_merge_core_assert.svh"

module grm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [grm_pkg::COL_W-1:0]     rect_col_first,
	input logic [grm_pkg::ROW_W-1:0]     rect_row_first,
	input logic [grm_pkg::COL_W-1:0]     rect_col_last,
	input logic [grm_pkg::ROW_W-1:0]     rect_row_last,
	input logic [grm_pkg::TILE_BITS-1:0] rect_tile,
	input logic                          scan_done
);

	logic rect_zero, rect_ordered;

	assign rect_zero = rect_col_first == '0 && rect_row_first == '0 &&
		rect_col_last == '0 && rect_row_last == '0 && rect_tile == '0;
	assign rect_ordered = rect_col_first <= rect_col_last && rect_row_first <= rect_row_last;

	`GRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`GRM_ASSERT_IMP(a_done_zero, out_valid && scan_done, rect_zero)
	`GRM_ASSERT_IMP(a_rect_order, out_valid && !scan_done, rect_ordered)
	`GRM_ASSERT_IMP(a_rect_tile, out_valid && !scan_done, rect_tile != '0)

endmodule

bind greedy_rectangle_merge_core grm_checker u_grm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.rect_col_first(rect_col_first),
	.rect_row_first(rect_row_first),
	.rect_col_last(rect_col_last),
	.rect_row_last(rect_row_last),
	.rect_tile(rect_tile),
	.scan_done(scan_done)
);

>>> verif/tb_greedy_rectangle_merge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle merge core testbench
// Loads tile grids of several sizes, fetches rectangles until a scan runs dry or
// a phase cap hits, and checks each result against a directed or predicted value.
// ----------------------------------------------------------------------------
module tb_greedy_rectangle_merge_core;

	localparam int COL_W     = grm_pkg::COL_W;
	localparam int ROW_W     = grm_pkg::ROW_W;
	localparam int DIM_W     = grm_pkg::DIM_W;
	localparam int TILE_BITS = grm_pkg::TILE_BITS;
	localparam int CELLS     = grm_pkg::CELLS;
	localparam int MAX_WIDTH = grm_pkg::MAX_WIDTH;

	localparam grm_pkg::cmd_t CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 4200;
	localparam int TOTAL_ITEMS = 800;

	typedef struct packed {
		logic [5:0] col_first;
		logic [5:0] row_first;
		logic [5:0] col_last;
		logic [5:0] row_last;
		logic [7:0] tile;
		logic       done;
	} rect_t;

	typedef struct {
		grm_pkg::cmd_t op;
		int            col;
		int            row;
		int            tile;
		bit            typed;
		rect_t         rect;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           cmd;
	logic [COL_W-1:0]     cell_col;
	logic [ROW_W-1:0]     cell_row;
	logic [TILE_BITS-1:0] cell_tile;
	logic                 out_valid;
	logic                 out_ready;
	logic [COL_W-1:0]     rect_col_first;
	logic [ROW_W-1:0]     rect_row_first;
	logic [COL_W-1:0]     rect_col_last;
	logic [ROW_W-1:0]     rect_row_last;
	logic [TILE_BITS-1:0] rect_tile;
	logic                 scan_done;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	greedy_rectangle_merge_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.cell_col(cell_col), .cell_row(cell_row), .cell_tile(cell_tile),
		.out_valid(out_valid), .out_ready(out_ready),
		.rect_col_first(rect_col_first), .rect_row_first(rect_row_first),
		.rect_col_last(rect_col_last), .rect_row_last(rect_row_last),
		.rect_tile(rect_tile), .scan_done(scan_done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [7:0] grid_tiles [CELLS];
	bit         grid_marks [CELLS];
	int         scan_c, scan_r;
	bit         scan_over;
	logic [6:0] dim_w, dim_h;

	rect_t pending_rects [$];
	int    fail_count;
	int    cycles;
	int    sent_items;
	bit    quiet;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("greedy_rectangle_merge_core test failed");
			$finish;
		end
	end

	// A long window in the middle of the run keeps both sides busy.
	assign quiet = (cycles >= 30000) && (cycles < 80000);

	always @(posedge clk)
		out_ready <= quiet || ($urandom_range(0, 99) >= 11);

	function automatic int eff_dim(input logic [6:0] v);
		if (v == 0) return 1;
		return (v > 64) ? 64 : int'(v);
	endfunction

	function automatic int cidx(input int c, input int r);
		return r * MAX_WIDTH + c;
	endfunction

	function automatic bit joins(input int c, input int r, input logic [7:0] t);
		return grid_tiles[cidx(c, r)] == t && !grid_marks[cidx(c, r)];
	endfunction

	function automatic void merge_step(input grm_pkg::cmd_t op, input logic [5:0] col,
			input logic [5:0] row, input logic [7:0] tile, output bit has, output rect_t res);
		int w, h, c, r, xe, ye, j;
		logic [7:0] t;
		bit found, sx, sy;
		has = 0;
		res = '0;
		found = 0;
		t = '0;
		case (op)
			grm_pkg::CMD_WRITE: begin
				grid_tiles[cidx(col, row)] = tile;
			end
			grm_pkg::CMD_RESTART: begin
				foreach (grid_marks[k]) grid_marks[k] = 0;
				scan_c = 0;
				scan_r = 0;
				scan_over = 0;
			end
			grm_pkg::CMD_FETCH: begin
				has = 1;
				w = eff_dim(dim_w);
				h = eff_dim(dim_h);
				c = scan_c;
				r = scan_r;
				if (!scan_over) begin
					while (r < h && !found) begin
						while (c < w) begin
							if (!grid_marks[cidx(c, r)] && grid_tiles[cidx(c, r)] != 0) begin
								t = grid_tiles[cidx(c, r)];
								found = 1;
								break;
							end
							c++;
						end
						if (!found) begin
							c = 0;
							r++;
						end
					end
				end
				if (!found) begin
					scan_over = 1;
					res.done = 1;
				end else begin
					scan_c = c;
					scan_r = r;
					xe = c;
					ye = r;
					sx = (c + 1) == w;
					sy = (r + 1) == h;
					// Grow one column, then one row, until both directions stop.
					while (!sx || !sy) begin
						if (!sx) begin
							for (j = r; j <= ye; j++)
								if (!joins(xe + 1, j, t)) begin
									sx = 1;
									break;
								end
							if (!sx) begin
								xe++;
								sx = (xe + 1) == w;
							end
						end
						if (!sy) begin
							for (j = c; j <= xe; j++)
								if (!joins(j, ye + 1, t)) begin
									sy = 1;
									break;
								end
							if (!sy) begin
								ye++;
								sy = (ye + 1) == h;
							end
						end
					end
					for (int rr = r; rr <= ye; rr++)
						for (int cc = c; cc <= xe; cc++)
							grid_marks[cidx(cc, rr)] = 1;
					res.col_first = c[5:0];
					res.row_first = r[5:0];
					res.col_last = xe[5:0];
					res.row_last = ye[5:0];
					res.tile = t;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		rect_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rects.size() == 0) begin
				$display("%0t: unexpected rectangle transfer, expected none, actual tile %0d",
					$time, rect_tile);
				fail_count++;
			end else begin
				want = pending_rects.pop_front();
				check_field("scan_done", want.done, scan_done);
				if (!want.done) begin
					check_field("rect_col_first", want.col_first, rect_col_first);
					check_field("rect_row_first", want.row_first, rect_row_first);
					check_field("rect_col_last", want.col_last, rect_col_last);
					check_field("rect_row_last", want.row_last, rect_row_last);
					check_field("rect_tile", want.tile, rect_tile);
				end
			end
		end
	end

	// Leaves in_valid high after the transfer so back-to-back items need no toggle.
	task automatic send_item(input grm_pkg::cmd_t op, input int col, input int row,
			input int tile, input bit typed, input rect_t typed_rect, output rect_t res,
			output bit has);
		if (!quiet && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 11) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		cell_col <= COL_W'(col);
		cell_row <= ROW_W'(row);
		cell_tile <= TILE_BITS'(tile);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		merge_step(op, 6'(col), 6'(row), 8'(tile), has, res);
		if (has) pending_rects.insert(pending_rects.size(), typed ? typed_rect : res);
		sent_items++;
	endtask

	// Lets the block go idle, including a restart clear that produces no result.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_rects.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input int w, input int h);
		cfg_valid <= 1'b1;
		cfg_index <= grm_pkg::REG_WIDTH;
		cfg_data <= DIM_W'(w);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		dim_w = DIM_W'(w);
		cfg_index <= grm_pkg::REG_HEIGHT;
		cfg_data <= DIM_W'(h);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		dim_h = DIM_W'(h);
		cfg_valid <= 1'b0;
	endtask

	stim_row_t directed [$];

	function automatic rect_t mk_rect(input int cf, input int rf, input int cl, input int rl,
			input int t, input bit d);
		rect_t x;
		x.col_first = 6'(cf);
		x.row_first = 6'(rf);
		x.col_last = 6'(cl);
		x.row_last = 6'(rl);
		x.tile = 8'(t);
		x.done = d;
		return x;
	endfunction

	function automatic void add_row(input grm_pkg::cmd_t op, input int col, input int row,
			input int t, input bit typed, input rect_t rect);
		stim_row_t s;
		s.op = op;
		s.col = col;
		s.row = row;
		s.tile = t;
		s.typed = typed;
		s.rect = rect;
		directed.insert(directed.size(), s);
	endfunction

	initial begin
		rect_t got, none, done_rect;
		bit has;
		int done_seen, phase_items, w, h, pick, cw, ch, pal0, pal1, t;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = grm_pkg::CMD_WRITE;
		cell_col = '0;
		cell_row = '0;
		cell_tile = '0;
		cfg_valid = 1'b0;
		cfg_index = grm_pkg::REG_WIDTH;
		cfg_data = '0;
		cycles = 0;
		sent_items = 0;
		fail_count = 0;
		foreach (grid_tiles[k]) begin
			grid_tiles[k] = '0;
			grid_marks[k] = 0;
		end
		scan_c = 0;
		scan_r = 0;
		scan_over = 0;
		dim_w = 7'd64;
		dim_h = 7'd64;
		none = '0;
		done_rect = mk_rect(0, 0, 0, 0, 0, 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a 2 x 2 grid.
		write_dims(2, 2);
		add_row(grm_pkg::CMD_WRITE, 0, 0, 255, 0, none);
		add_row(grm_pkg::CMD_WRITE, 1, 0, 255, 0, none);
		add_row(grm_pkg::CMD_WRITE, 0, 1, 255, 0, none);
		add_row(grm_pkg::CMD_WRITE, 1, 1, 1, 0, none);
		add_row(CMD_UNUSED, 63, 63, 255, 0, none);
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 1, mk_rect(0, 0, 1, 0, 255, 0));
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 1, mk_rect(0, 1, 0, 1, 255, 0));
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 1, mk_rect(1, 1, 1, 1, 1, 0));
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 1, done_rect);
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 1, done_rect);
		add_row(grm_pkg::CMD_WRITE, 63, 63, 0, 0, none);
		add_row(grm_pkg::CMD_WRITE, 1, 1, 255, 0, none);
		add_row(grm_pkg::CMD_RESTART, 0, 0, 0, 0, none);
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 1, mk_rect(0, 0, 1, 1, 255, 0));
		add_row(grm_pkg::CMD_WRITE, 0, 0, 0, 0, none);
		add_row(grm_pkg::CMD_RESTART, 0, 0, 0, 0, none);
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 0, none);
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 0, none);
		add_row(grm_pkg::CMD_FETCH, 0, 0, 0, 1, done_rect);
		foreach (directed[i])
			send_item(directed[i].op, directed[i].col, directed[i].row, directed[i].tile,
				directed[i].typed, directed[i].rect, got, has);

		// Random phases, each under its own grid size.
		for (int phase = 0; sent_items < TOTAL_ITEMS; phase++) begin
			drain();
			case (phase)
				0: begin cw = 0; ch = 0; end
				1: begin cw = 127; ch = 1; end
				2: begin cw = 1; ch = 64; end
				3: begin cw = 2; ch = 100; end
				4: begin cw = 100; ch = 2; end
				default: begin
					cw = $urandom_range(1, 9);
					ch = $urandom_range(1, 9);
				end
			endcase
			write_dims(cw, ch);
			w = eff_dim(DIM_W'(cw));
			h = eff_dim(DIM_W'(ch));
			pal0 = $urandom_range(1, 255);
			pal1 = $urandom_range(0, 255);
			// Blocky fill so that rectangles actually merge.
			for (int r = 0; r < h; r++)
				for (int c = 0; c < w; c++) begin
					if ($urandom_range(0, 9) == 0)
						t = $urandom_range(0, 255);
					else
						t = (((c >> 1) + (r >> 1)) & 1) ? pal1 : pal0;
					send_item(grm_pkg::CMD_WRITE, c, r, t, 0, none, got, has);
				end
			// Without a restart the scan resumes from its saved spot under the new size.
			if (phase < 5 || $urandom_range(0, 1))
				send_item(grm_pkg::CMD_RESTART, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 255), 0, none, got, has);
			done_seen = 0;
			phase_items = 0;
			while (done_seen < 2 && phase_items < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_item(grm_pkg::CMD_FETCH, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 255), 0, none, got, has);
				else if (pick < 88)
					send_item(grm_pkg::CMD_WRITE, $urandom_range(0, w - 1),
						$urandom_range(0, h - 1), ($urandom_range(0, 1) ? pal0 : pal1),
						0, none, got, has);
				else if (pick < 94)
					send_item(grm_pkg::CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 255), 0, none, got, has);
				else if (pick < 97)
					send_item(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 255), 0, none, got, has);
				else
					send_item(grm_pkg::CMD_RESTART, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 255), 0, none, got, has);
				if (has && got.done) done_seen++;
				phase_items++;
			end
		end

		drain();
		if (fail_count == 0)
			$display("greedy_rectangle_merge_core test passed");
		else
			$display("greedy_rectangle_merge_core test failed");
		$finish;
	end

endmodule
